FILE: src/sync_length_crc_frame_parser_assert.svh
// assertion macros for the sync/length/crc frame parser
// depends on nothing; included by the modules that carry assertions
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// plain property checked on every clock edge outside reset
`define SLCFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define SLCFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SLCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SLCFP_ASSERT(label, clk, rst, prop, msg)
`define SLCFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SLCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/slcfp_pkg.sv
// shared types, constants and the byte-wide crc update for the frame parser
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package slcfp_pkg;

   localparam int MAX_PAYLOAD = 256;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int CRC_W      = 16;
   localparam int CNT_W      = $clog2(MAX_PAYLOAD + 1);
   localparam int IMU_LEN_W  = 9;
   localparam int STATUS_W   = 2;
   localparam int EVT_W      = 32;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;
   localparam logic [BYTE_W-1:0] END_BYTE    = 8'h33;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h8408;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ETX_ERR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMU_MSG_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMU_LENGTH = 1'd1;

   localparam logic [BYTE_W-1:0]    IMU_MSG_ID_RST = 8'd2;
   localparam logic [IMU_LEN_W-1:0] IMU_LENGTH_RST = 9'd34;

   typedef enum logic [8:0] {
      PH_SYNC1   = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_ID      = 9'b000000100,
      PH_LEN_LO  = 9'b000001000,
      PH_LEN_HI  = 9'b000010000,
      PH_PAYLOAD = 9'b000100000,
      PH_CRC_LO  = 9'b001000000,
      PH_CRC_HI  = 9'b010000000,
      PH_END     = 9'b100000000
   } phase_type;

   // item held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] in_byte;
   } slot_type;

   // one result item
   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   payload_index;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   frame_msg_id;
      logic [LEN_W-1:0]    frame_length;
      logic                imu_match;
      logic [EVT_W-1:0]    good_frames;
      logic [EVT_W-1:0]    crc_errors;
      logic [EVT_W-1:0]    etx_errors;
      logic [EVT_W-1:0]    length_errors;
      logic [EVT_W-1:0]    headers_seen;
   } rsp_item_type;

   // crc-16/kermit, reflected, one byte
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: src/slcfp_if.sv
// valid/ready channel interfaces for the frame parser input and result items
// depends on slcfp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface slcfp_req_if import slcfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface slcfp_rsp_if import slcfp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [BYTE_W-1:0]   payload_index;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   frame_msg_id;
   logic [LEN_W-1:0]    frame_length;
   logic                imu_match;
   logic [EVT_W-1:0]    good_frames;
   logic [EVT_W-1:0]    crc_errors;
   logic [EVT_W-1:0]    etx_errors;
   logic [EVT_W-1:0]    length_errors;
   logic [EVT_W-1:0]    headers_seen;

   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output status, output frame_msg_id, output frame_length,
                   output imu_match, output good_frames, output crc_errors,
                   output etx_errors, output length_errors, output headers_seen,
                   input ready);
   modport sink   (input valid, input kind, input payload_byte, input payload_index,
                   input status, input frame_msg_id, input frame_length,
                   input imu_match, input good_frames, input crc_errors,
                   input etx_errors, input length_errors, input headers_seen,
                   output ready);
endinterface

`default_nettype wire

FILE: src/slcfp_in_stage.sv
// input register of the frame parser: holds one received byte for the core
// depends on slcfp_pkg and slcfp_req_if
`timescale 1ns / 1ps
`default_nettype none

module slcfp_in_stage import slcfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   slcfp_req_if.sink   req_chan,
   input  logic        take,
   output slot_type    slot
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_chan.in_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign slot.valid   = valid_ff;
   assign slot.in_byte = byte_ff;

endmodule

`default_nettype wire

FILE: src/slcfp_core.sv
// frame parser core: phase machine, crc update, counters and result build
// depends on slcfp_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sync_length_crc_frame_parser_assert.svh"

module slcfp_core import slcfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  slot_type              slot,
   input  logic                  out_ready,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                  take,
   output logic                  item_valid,
   output rsp_item_type          item
);

   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      msg_id_ff, msg_id_in;
   logic [BYTE_W-1:0]      len_low_ff, len_low_in;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CRC_W-1:0]       rx_crc_ff, rx_crc_in;
   logic [CRC_W-1:0]       crc_ff, crc_in;
   logic [EVT_W-1:0]       good_ff, good_in;
   logic [EVT_W-1:0]       crc_err_ff, crc_err_in;
   logic [EVT_W-1:0]       etx_err_ff, etx_err_in;
   logic [EVT_W-1:0]       len_err_ff, len_err_in;
   logic [EVT_W-1:0]       hdr_ff, hdr_in;
   logic [BYTE_W-1:0]      imu_id_ff, imu_id_in;
   logic [IMU_LEN_W-1:0]   imu_len_ff, imu_len_in;

   logic [BYTE_W-1:0]   b;
   logic [LEN_W-1:0]    new_len;
   logic                too_big;
   logic [CNT_W-1:0]    count_next;
   logic [CRC_W-1:0]    crc_upd;
   logic                hdr_hit, len_hit, etx_hit, crc_hit, good_hit;
   logic                in_payload, in_end, makes_result;
   logic [LEN_W-1:0]    verdict_len;
   logic [STATUS_W-1:0] verdict_status;

   assign b          = slot.in_byte;
   assign new_len    = {b, len_low_ff};
   assign too_big    = new_len > LEN_W'(MAX_PAYLOAD);
   assign count_next = count_ff + CNT_W'(1);
   assign crc_upd    = crc_feed(crc_ff, b);
   assign in_payload = phase_ff == PH_PAYLOAD;
   assign in_end     = phase_ff == PH_END;

   // events of the current item
   assign hdr_hit  = slot.valid && phase_ff == PH_SYNC2 && b == SYNC_SECOND;
   assign len_hit  = slot.valid && phase_ff == PH_LEN_HI && too_big;
   assign etx_hit  = slot.valid && in_end && b != END_BYTE;
   assign crc_hit  = slot.valid && in_end && b == END_BYTE && crc_ff != rx_crc_ff;
   assign good_hit = slot.valid && in_end && b == END_BYTE && crc_ff == rx_crc_ff;

   assign makes_result = slot.valid && (in_payload || in_end || len_hit);
   assign item_valid   = makes_result;
   assign take         = slot.valid && (!makes_result || out_ready);

   assign good_in    = good_ff    + EVT_W'(good_hit);
   assign crc_err_in = crc_err_ff + EVT_W'(crc_hit);
   assign etx_err_in = etx_err_ff + EVT_W'(etx_hit);
   assign len_err_in = len_err_ff + EVT_W'(len_hit);
   assign hdr_in     = hdr_ff     + EVT_W'(hdr_hit);

   always_comb begin
      phase_in   = phase_ff;
      msg_id_in  = msg_id_ff;
      len_low_in = len_low_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      rx_crc_in  = rx_crc_ff;
      crc_in     = crc_ff;
      case (phase_ff)
         PH_SYNC1: begin
            if (b == SYNC_FIRST) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               crc_in   = '0;
               phase_in = PH_ID;
            end else if (b != SYNC_FIRST) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_ID: begin
            msg_id_in = b;
            crc_in    = crc_upd;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_low_in = b;
            crc_in     = crc_upd;
            phase_in   = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = new_len;
            crc_in    = crc_upd;
            count_in  = '0;
            if (too_big) begin
               phase_in = PH_SYNC1;
            end else if (new_len == '0) begin
               phase_in = PH_CRC_LO;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_in   = crc_upd;
            count_in = count_next;
            if (LEN_W'(count_next) >= length_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            rx_crc_in = {{(CRC_W-BYTE_W){1'b0}}, b};
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            rx_crc_in = {b, rx_crc_ff[BYTE_W-1:0]};
            phase_in  = PH_END;
         end
         PH_END: begin
            phase_in = PH_SYNC1;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      imu_id_in  = imu_id_ff;
      imu_len_in = imu_len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMU_MSG_ID: imu_id_in  = csr_wr_data[BYTE_W-1:0];
            CSR_IMU_LENGTH: imu_len_in = csr_wr_data[IMU_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // result build
   always_comb begin
      if (len_hit) begin
         verdict_status = STATUS_LEN_ERR;
      end else if (etx_hit) begin
         verdict_status = STATUS_ETX_ERR;
      end else if (crc_hit) begin
         verdict_status = STATUS_CRC_ERR;
      end else begin
         verdict_status = STATUS_OK;
      end
      verdict_len = len_hit ? new_len : length_ff;
      item = '0;
      if (in_payload) begin
         item.kind          = KIND_PAYLOAD;
         item.payload_byte  = b;
         item.payload_index = BYTE_W'(count_ff);
      end else begin
         item.kind          = KIND_VERDICT;
         item.status        = verdict_status;
         item.frame_msg_id  = msg_id_ff;
         item.frame_length  = verdict_len;
         item.imu_match     = verdict_status == STATUS_OK && msg_id_ff == imu_id_ff &&
                              verdict_len == LEN_W'(imu_len_ff);
         item.good_frames   = good_in;
         item.crc_errors    = crc_err_in;
         item.etx_errors    = etx_err_in;
         item.length_errors = len_err_in;
         item.headers_seen  = hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         msg_id_ff  <= '0;
         len_low_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         rx_crc_ff  <= '0;
         crc_ff     <= '0;
         good_ff    <= '0;
         crc_err_ff <= '0;
         etx_err_ff <= '0;
         len_err_ff <= '0;
         hdr_ff     <= '0;
         imu_id_ff  <= IMU_MSG_ID_RST;
         imu_len_ff <= IMU_LENGTH_RST;
      end else begin
         if (take) begin
            phase_ff   <= phase_in;
            msg_id_ff  <= msg_id_in;
            len_low_ff <= len_low_in;
            length_ff  <= length_in;
            count_ff   <= count_in;
            rx_crc_ff  <= rx_crc_in;
            crc_ff     <= crc_in;
            good_ff    <= good_in;
            crc_err_ff <= crc_err_in;
            etx_err_ff <= etx_err_in;
            len_err_ff <= len_err_in;
            hdr_ff     <= hdr_in;
         end
         imu_id_ff  <= imu_id_in;
         imu_len_ff <= imu_len_in;
      end
   end

   `SLCFP_ASSERT_IMPL(a_payload_in_range, clock, reset, phase_ff == PH_PAYLOAD, LEN_W'(count_ff) < length_ff && length_ff <= LEN_W'(MAX_PAYLOAD), "payload count out of range")
   `SLCFP_ASSERT_NEXT(a_verdict_resyncs, clock, reset, take && item_valid && item.kind == KIND_VERDICT, phase_ff == PH_SYNC1, "parser not back to sync hunt after verdict")
   `SLCFP_ASSERT_NEXT(a_good_steps, clock, reset, take && good_hit, good_ff == $past(good_ff) + EVT_W'(1), "good frame counter did not step")
   `SLCFP_ASSERT_IMPL(a_result_needs_room, clock, reset, take && item_valid, out_ready, "result taken without room in output register")

endmodule

`default_nettype wire

FILE: src/slcfp_out_stage.sv
// output register of the frame parser: holds one result item for the sink
// depends on slcfp_pkg and slcfp_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module slcfp_out_stage import slcfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  rsp_item_type  item,
   output logic          out_ready,
   slcfp_rsp_if.source   rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;
   logic         load;

   assign out_ready = !valid_ff || rsp_chan.ready;
   assign load      = item_valid && out_ready;
   assign valid_in  = load || (valid_ff && !rsp_chan.ready);
   assign item_in   = load ? item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = item_ff.kind;
   assign rsp_chan.payload_byte  = item_ff.payload_byte;
   assign rsp_chan.payload_index = item_ff.payload_index;
   assign rsp_chan.status        = item_ff.status;
   assign rsp_chan.frame_msg_id  = item_ff.frame_msg_id;
   assign rsp_chan.frame_length  = item_ff.frame_length;
   assign rsp_chan.imu_match     = item_ff.imu_match;
   assign rsp_chan.good_frames   = item_ff.good_frames;
   assign rsp_chan.crc_errors    = item_ff.crc_errors;
   assign rsp_chan.etx_errors    = item_ff.etx_errors;
   assign rsp_chan.length_errors = item_ff.length_errors;
   assign rsp_chan.headers_seen  = item_ff.headers_seen;

endmodule

`default_nettype wire

FILE: src/sync_length_crc_frame_parser.sv
// framed serial parser: one received byte per input item; hunts for the sync
// pair ff 5a, reads id, little-endian length, payload, little-endian crc-16/kermit
// and end byte 33, passes each payload byte out as a result item and closes each
// frame with one verdict item carrying wrapping event counters. one byte is taken
// per clock unless its result finds no room in the output register; a byte passes
// the input register, the combinational parse and crc logic and then the output
// register. bytes that give no result keep flowing while a result waits at rsp.
// depends on slcfp_pkg, slcfp_if, slcfp_in_stage, slcfp_core, slcfp_out_stage
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc_frame_parser import slcfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   slcfp_req_if.sink             req_chan,
   slcfp_rsp_if.source           rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // input register to core
   slot_type     slot;
   logic         take;

   // core to output register
   logic         item_valid;
   rsp_item_type item;
   logic         out_ready;

   // input register: one byte held for the parse logic
   slcfp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .slot     (slot)
   );

   // phase machine, crc, counters and imu settings
   slcfp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .slot        (slot),
      .out_ready   (out_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .item_valid  (item_valid),
      .item        (item)
   );

   // output register toward the result sink
   slcfp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_ready  (out_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
